/* hdl/lgs_pkg.sv */
// Shared types and constants for the life grid generation step block.
package lgs_pkg;

    // Grid size. The sweep moves one row per cycle.
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    // Field and register widths.
    localparam int ACTION_W = 2;
    localparam int ADDR_W   = 6;
    localparam int CFG_W    = 7;
    localparam int STEP_W   = $clog2(MAX_ROWS);

    // Width of the neighbor count, enough for eight neighbors.
    localparam int COUNT_W  = 4;

    typedef logic [MAX_COLS-1:0] row_t;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // Rule B3/S23 neighbor counts.
    localparam logic [COUNT_W-1:0] SURVIVE_COUNT = 4'd2;
    localparam logic [COUNT_W-1:0] BIRTH_COUNT   = 4'd3;

endpackage

/* hdl/lgs_row_cell.sv */
// One row register of the circulating grid chain.
module lgs_row_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  lgs_pkg::row_t d,
    output lgs_pkg::row_t q
);
    import lgs_pkg::*;

    row_t row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else if (shift)
        begin
            row_reg <= d;
        end
    end

    assign q = row_reg;

endmodule

/* hdl/lgs_row_rule.sv */
// Next-generation row from a three-row window under the B3/S23 rule.
module lgs_row_rule (
    input  lgs_pkg::row_t above,
    input  lgs_pkg::row_t mid,
    input  lgs_pkg::row_t below,
    input  lgs_pkg::row_t col_mask,
    output lgs_pkg::row_t next_row
);
    import lgs_pkg::*;

    row_t a;
    row_t m;
    row_t b;

    // Columns outside the grid in use count as dead.
    assign a = above & col_mask;
    assign m = mid & col_mask;
    assign b = below & col_mask;

    always_comb
    begin
        logic [COUNT_W-1:0] n;
        next_row = mid;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            n = COUNT_W'(a[c]) + COUNT_W'(b[c]);
            if (c > 0)
            begin
                n = n + COUNT_W'(a[c-1]) + COUNT_W'(m[c-1]) + COUNT_W'(b[c-1]);
            end
            if (c < MAX_COLS - 1)
            begin
                n = n + COUNT_W'(a[c+1]) + COUNT_W'(m[c+1]) + COUNT_W'(b[c+1]);
            end
            if (col_mask[c])
            begin
                if (m[c])
                begin
                    next_row[c] = (n == SURVIVE_COUNT) || (n == BIRTH_COUNT);
                end
                else
                begin
                    next_row[c] = (n == BIRTH_COUNT);
                end
            end
        end
    end

endmodule

/* hdl/life_grid_generation_step.sv */
// Top level of the life grid generation step block.
//
// The block keeps a grid of one-bit cells, all dead after reset, and runs
// one command per transfer. A command is taken at a rising edge where start
// is high and busy is low; action selects write cell, read cell, or advance
// one generation by the B3/S23 rule, and row, col and value address the cell.
// Every command returns one result: cell_alive, the addressed cell after the
// action, shown for exactly one cycle with done high. Addresses outside the
// grid in use return 0, and writes to them are dropped.
//
// The grid lives in a chain of row registers that circulates one row per
// cycle past a rule unit with a three-row window. Each command makes one
// full lap of the chain, and done is raised as the lap ends; the result is
// taken at the edge that closes the done cycle. A new command can be taken
// in the cycle that done is high.
//
// The receiver cannot stall; a result must be taken in its done cycle. Reset
// clears the grid and sets both size registers to their maximum. The user
// writes rows_in_use and cols_in_use through cfg_write, cfg_index and cfg_data
// while idle; the block does not enforce this. Stored cells stay on a change.
module life_grid_generation_step (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [lgs_pkg::ACTION_W-1:0] action,
    input  logic [lgs_pkg::ADDR_W-1:0]   row,
    input  logic [lgs_pkg::ADDR_W-1:0]   col,
    input  logic                         value,
    output logic                         done,
    output logic                         cell_alive,
    input  logic                         cfg_write,
    input  logic                         cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]    cfg_data
);
    import lgs_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } state_t;

    state_t                state_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [ACTION_W-1:0]   action_reg;
    logic [ADDR_W-1:0]     row_reg;
    logic [ADDR_W-1:0]     col_reg;
    logic                  value_reg;
    logic                  done_reg;
    logic                  cell_alive_reg;
    row_t                  prev_reg;
    logic [CFG_W-1:0]      rows_cfg_reg;
    logic [CFG_W-1:0]      cols_cfg_reg;

    row_t                  row_q [MAX_ROWS];
    row_t                  updated_row;
    row_t                  rule_row;
    row_t                  col_mask;
    row_t                  above_row;
    row_t                  below_row;
    logic [31:0]           rows_lim;
    logic [31:0]           cols_lim;
    logic                  hit;
    logic                  row_in_use;
    logic                  at_target;
    logic                  target_bit;
    logic                  last_step;

    // Size registers saturate at the grid dimensions.
    assign rows_lim = (32'(rows_cfg_reg) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(rows_cfg_reg);
    assign cols_lim = (32'(cols_cfg_reg) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(cols_cfg_reg);

    assign hit        = (32'(row_reg) < rows_lim) && (32'(col_reg) < cols_lim);
    assign row_in_use = 32'(step_reg) < rows_lim;
    assign at_target  = 32'(step_reg) == 32'(row_reg);
    assign last_step  = 32'(step_reg) == 32'(MAX_ROWS - 1);

    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_mask[c] = 32'(c) < cols_lim;
        end
    end

    // The head of the chain holds row step_reg, the next cell holds the old
    // row below it, and prev_reg keeps the old row above it.
    assign above_row = (step_reg == '0) ? '0 : prev_reg;
    assign below_row = ((32'(step_reg) + 32'd1) < rows_lim) ? row_q[1] : '0;

    lgs_row_rule u_rule (
        .above    (above_row),
        .mid      (row_q[0]),
        .below    (below_row),
        .col_mask (col_mask),
        .next_row (rule_row)
    );

    // Row that goes back into the tail of the chain.
    always_comb
    begin
        updated_row = row_q[0];
        if (action_reg == ACT_ADVANCE)
        begin
            if (row_in_use)
            begin
                updated_row = rule_row;
            end
        end
        else if ((action_reg == ACT_WRITE) && at_target && hit)
        begin
            for (int c = 0; c < MAX_COLS; c++)
            begin
                if (32'(c) == 32'(col_reg))
                begin
                    updated_row[c] = value_reg;
                end
            end
        end
    end

    always_comb
    begin
        target_bit = 1'b0;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            if (32'(c) == 32'(col_reg))
            begin
                target_bit = updated_row[c];
            end
        end
    end

    // Circulating chain of row cells: each takes its neighbor's row every
    // sweep cycle, and the tail takes the updated head row.
    for (genvar k = 0; k < MAX_ROWS; k++)
    begin : g_chain
        if (k == MAX_ROWS - 1)
        begin : g_tail
            lgs_row_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (state_reg == ST_SWEEP),
                .d     (updated_row),
                .q     (row_q[k])
            );
        end
        else
        begin : g_body
            lgs_row_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (state_reg == ST_SWEEP),
                .d     (row_q[k+1]),
                .q     (row_q[k])
            );
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= CFG_W'(MAX_ROWS);
            cols_cfg_reg <= CFG_W'(MAX_COLS);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ROWS: rows_cfg_reg <= cfg_data;
                CFG_COLS: cols_cfg_reg <= cfg_data;
                default:  rows_cfg_reg <= rows_cfg_reg;
            endcase
        end
    end

    // Sequencer: state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            done_reg       <= 1'b0;
            cell_alive_reg <= 1'b0;
            action_reg     <= ACT_READ;
            row_reg        <= '0;
            col_reg        <= '0;
            value_reg      <= 1'b0;
            prev_reg       <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        action_reg <= action;
                        row_reg    <= row;
                        col_reg    <= col;
                        value_reg  <= value;
                        step_reg   <= '0;
                        state_reg  <= ST_SWEEP;
                    end
                end
                ST_SWEEP:
                begin
                    prev_reg <= row_q[0];
                    if (at_target)
                    begin
                        cell_alive_reg <= hit & target_bit;
                    end
                    if (last_step)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                        if (!hit)
                        begin
                            cell_alive_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign cell_alive = cell_alive_reg;

endmodule

/* hdl/lgs_checker.sv */
// Port-level checker for the life grid generation step block, with its bind.
module lgs_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cell_alive
);
    import lgs_pkg::*;

    // A result is shown only once the block has gone idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // An accepted command makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    // Every accepted command returns its result after one full lap.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(MAX_ROWS + 1) done)
        else $error("result missing after sweep");

    // A result strobe lasts one cycle.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // The result bit is only meaningful with the strobe; it holds outside it
    // unless a sweep is running.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !done && !$past(busy)) |-> $stable(cell_alive))
        else $error("result changed while idle");

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .cell_alive (cell_alive)
);

/* tb/life_grid_generation_step_test.sv */
// Self-checking testbench for the life grid generation step block.
module life_grid_generation_step_test;

    import lgs_pkg::*;

    // Action code 3 has no name in the package; the block treats it as a read.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Cycles of quiet after the last result before the size registers change.
    localparam int SETTLE_CYCLES   = 4;
    // Cycles without any transfer before the run is declared hung. The longest
    // honest quiet stretch is the longest sender gap plus one command lap.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 83;
    localparam int MAX_REPORTS     = 10;

    // One outstanding command and the cell state it should report.
    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [ADDR_W-1:0]   row;
        logic [ADDR_W-1:0]   col;
        logic                alive;
    } cell_expectation_t;

    // The scoreboard keeps its own copy of the grid and the size registers.
    // Every accepted command is applied to that copy right away, and the cell
    // state it yields is queued until the block returns the matching result.
    class grid_scoreboard;
        row_t                grid[MAX_ROWS];
        logic [CFG_W-1:0]    rows_reg;
        logic [CFG_W-1:0]    cols_reg;
        cell_expectation_t   expected_cells[$];
        int                  failures;
        int                  reports;
        int                  results_checked;
        int                  writes;
        int                  reads;
        int                  advances;
        int                  sizes;

        function new();
            foreach (grid[i]) grid[i] = '0;
            rows_reg = CFG_W'(MAX_ROWS);
            cols_reg = CFG_W'(MAX_COLS);
        endfunction

        function void set_register(logic index, logic [CFG_W-1:0] data);
            if (index == CFG_ROWS)
                rows_reg = data;
            else
                cols_reg = data;
        endfunction

        // Register values above the grid size saturate.
        function int active_rows();
            return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
        endfunction

        function int active_cols();
            return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction

        // One B3/S23 generation over the grid in use. Neighbors outside the
        // grid in use count as dead, and cells out there keep their state.
        function void step_generation();
            row_t next_rows[MAX_ROWS];
            int   nr;
            int   nc;
            int   count;
            int   rr;
            int   cc;
            nr = active_rows();
            nc = active_cols();
            next_rows = grid;
            for (int r = 0; r < nr; r++) begin
                for (int c = 0; c < nc; c++) begin
                    count = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            rr = r + dr;
                            cc = c + dc;
                            if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 &&
                                rr < nr && cc < nc && grid[rr][cc])
                                count++;
                        end
                    end
                    if (grid[r][c])
                        next_rows[r][c] = (count == SURVIVE_COUNT) || (count == BIRTH_COUNT);
                    else
                        next_rows[r][c] = (count == BIRTH_COUNT);
                end
            end
            grid = next_rows;
        endfunction

        function void note_command(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] r,
                                   logic [ADDR_W-1:0] c, logic v);
            cell_expectation_t item;
            bit                hit;
            hit = (r < active_rows()) && (c < active_cols());
            case (act)
                ACT_WRITE:
                begin
                    writes++;
                    if (hit)
                        grid[r][c] = v;
                end
                ACT_ADVANCE:
                begin
                    advances++;
                    step_generation();
                end
                default:
                begin
                    reads++;
                end
            endcase
            item.action = act;
            item.row    = r;
            item.col    = c;
            item.alive  = hit ? grid[r][c] : 1'b0;
            expected_cells = {expected_cells, item};
        endfunction

        function void check_result(logic got);
            cell_expectation_t item;
            if (expected_cells.size() == 0) begin
                failures++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("unexpected result: cell_alive %0b with no command pending", got);
                end
                return;
            end
            item = expected_cells.pop_front();
            results_checked++;
            if (got !== item.alive) begin
                failures++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("mismatch: action %0d row %0d col %0d cell_alive expected %0b got %0b",
                             item.action, item.row, item.col, item.alive, got);
                end
            end
        endfunction

        function void check_leftover();
            if (expected_cells.size() != 0) begin
                failures += expected_cells.size();
                $display("%0d results never arrived", expected_cells.size());
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   row;
    logic [ADDR_W-1:0]   col;
    logic                value;
    logic                done;
    logic                cell_alive;
    logic                cfg_write;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    grid_scoreboard      sb;
    int                  quiet_cycles;

    life_grid_generation_step dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .row        (row),
        .col        (col),
        .value      (value),
        .done       (done),
        .cell_alive (cell_alive),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Result side. The block cannot be held off, so every done cycle is one
    // result transfer and is checked against the oldest pending command. The
    // DUT updates its outputs with nonblocking assignments, so the values read
    // here are the ones that stood during the cycle that this edge closes.
    // The watchdog is cleared by a transfer on either side.
    always @(posedge clk) begin
        if (!rst_n) begin
            quiet_cycles <= 0;
        end
        else begin
            if (done)
                sb.check_result(cell_alive);
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Called at a falling edge. Raises start with the command and holds it
    // until the block takes it, then returns at the next falling edge with
    // start still high; the caller either sends again or lowers start, so
    // start never gets two updates in one time step.
    task automatic send_command(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] r,
                                input logic [ADDR_W-1:0] c, input logic v);
        start  <= 1'b1;
        action <= act;
        row    <= r;
        col    <= c;
        value  <= v;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(act, r, c, v);
        @(negedge clk);
    endtask

    // Sender gap of the given length, at least one cycle.
    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Stop sending and wait for every pending result, then wait out the settle time
    // so that the block is certainly back at rest.
    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes both size registers on back-to-back edges; the block must be idle.
    task automatic set_grid_size(input logic [CFG_W-1:0] rows_val,
                                 input logic [CFG_W-1:0] cols_val);
        cfg_write <= 1'b1;
        cfg_index <= CFG_ROWS;
        cfg_data  <= rows_val;
        @(negedge clk);
        cfg_index <= CFG_COLS;
        cfg_data  <= cols_val;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.set_register(CFG_ROWS, rows_val);
        sb.set_register(CFG_COLS, cols_val);
        sb.sizes++;
    endtask

    // Random index inside the grid in use, or anywhere when nothing is in use.
    function automatic logic [ADDR_W-1:0] pick_index(input int span);
        if (span > 0)
            return ADDR_W'($urandom_range(0, span - 1));
        return ADDR_W'($urandom_range(0, MAX_ROWS - 1));
    endfunction

    initial begin
        int                  roll;
        int                  rows_val;
        int                  cols_val;
        bit                  idling;
        logic [ACTION_W-1:0] act;
        logic [ADDR_W-1:0]   r;
        logic [ADDR_W-1:0]   c;
        logic                v;

        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        action    = ACT_READ;
        row       = '0;
        col       = '0;
        value     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_ROWS;
        cfg_data  = '0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part on the full 64 by 64 grid left by reset. The four
        // corners are set and then die alone; a blinker flips and a block
        // holds still across generations.
        send_command(ACT_READ, 6'd0, 6'd0, 1'b0);
        send_command(ACT_WRITE, 6'd0, 6'd0, 1'b1);
        send_command(ACT_WRITE, 6'd63, 6'd63, 1'b1);
        send_command(ACT_WRITE, 6'd63, 6'd0, 1'b1);
        send_command(ACT_WRITE, 6'd0, 6'd63, 1'b1);
        send_command(ACT_UNUSED, 6'd63, 6'd63, 1'b0);
        send_command(ACT_ADVANCE, 6'd0, 6'd0, 1'b0);
        send_command(ACT_WRITE, 6'd30, 6'd20, 1'b1);
        send_command(ACT_WRITE, 6'd30, 6'd21, 1'b1);
        send_command(ACT_WRITE, 6'd30, 6'd22, 1'b1);
        send_command(ACT_ADVANCE, 6'd29, 6'd21, 1'b0);
        send_command(ACT_WRITE, 6'd5, 6'd5, 1'b1);
        send_command(ACT_WRITE, 6'd5, 6'd6, 1'b1);
        send_command(ACT_WRITE, 6'd6, 6'd5, 1'b1);
        send_command(ACT_WRITE, 6'd6, 6'd6, 1'b1);
        send_command(ACT_ADVANCE, 6'd6, 6'd6, 1'b0);
        send_command(ACT_WRITE, 6'd5, 6'd5, 1'b0);
        // The value field means nothing to a read.
        send_command(ACT_READ, 6'd30, 6'd20, 1'b1);
        drain_results();

        // A 3 by 3 grid: writes outside it are dropped, and a vertical
        // blinker on the middle column sees the border as dead cells. The
        // cells stored outside stay as they are through the advance.
        set_grid_size(7'd3, 7'd3);
        send_command(ACT_WRITE, 6'd5, 6'd5, 1'b1);
        send_command(ACT_WRITE, 6'd0, 6'd1, 1'b1);
        send_command(ACT_WRITE, 6'd1, 6'd1, 1'b1);
        send_command(ACT_WRITE, 6'd2, 6'd1, 1'b1);
        send_command(ACT_ADVANCE, 6'd1, 6'd0, 1'b0);
        drain_results();

        // No rows in use with a saturated column count: the advance is a no-op.
        set_grid_size(7'd0, 7'd127);
        send_command(ACT_ADVANCE, 6'd1, 6'd1, 1'b0);
        drain_results();

        // No columns in use with a saturated row count: the write is dropped.
        set_grid_size(7'd127, 7'd0);
        send_command(ACT_WRITE, 6'd0, 6'd0, 1'b1);
        drain_results();

        // Random phases, each on its own grid size. Most commands are writes,
        // reads and advances inside the grid in use, so patterns build up and
        // evolve over many generations; a few use code 3 or any address.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       begin rows_val = 8;  cols_val = 8;  end
                1:       begin rows_val = 1;  cols_val = 64; end
                2:       begin rows_val = 64; cols_val = 2;  end
                3:       begin rows_val = 64; cols_val = 64; end
                4:       begin rows_val = $urandom_range(65, 127); cols_val = $urandom_range(3, 10); end
                5:       begin rows_val = $urandom_range(3, 10); cols_val = $urandom_range(65, 127); end
                default: begin rows_val = $urandom_range(2, 20); cols_val = $urandom_range(2, 20); end
            endcase
            set_grid_size(CFG_W'(rows_val), CFG_W'(cols_val));
            // One phase sends commands back to back with no sender gaps; it still drains now and then.
            idling = (phase != 6);

            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                roll = $urandom_range(0, 99);
                r    = pick_index(sb.active_rows());
                c    = pick_index(sb.active_cols());
                v    = ($urandom_range(0, 99) < 55);
                if (roll < 45)
                    act = ACT_WRITE;
                else if (roll < 70)
                    act = ACT_READ;
                else if (roll < 90)
                    act = ACT_ADVANCE;
                else if (roll < 95)
                    act = ACT_UNUSED;
                else begin
                    act = ACTION_W'($urandom_range(0, 3));
                    r   = ADDR_W'($urandom_range(0, 63));
                    c   = ADDR_W'($urandom_range(0, 63));
                    v   = 1'($urandom_range(0, 1));
                end
                send_command(act, r, c, v);
                // Random sender gaps put the next start at any point of the block's lap.
                // Now and then the sender waits for every result to come back before it
                // goes on.
                if (idling && $urandom_range(0, 99) < 20)
                    hold_off($urandom_range(1, 80));
                else if ($urandom_range(0, 99) < 2)
                    drain_results();
            end
            drain_results();
        end

        repeat (MAX_ROWS + 2) @(negedge clk);
        sb.check_leftover();

        $display("Checked %0d results from %0d writes, %0d reads and %0d advances.",
                 sb.results_checked, sb.writes, sb.reads, sb.advances);
        $display("Grid sizes tried: %0d, from zero and single rows or columns up to saturation.",
                 sb.sizes);
        if (sb.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
